// ----- rtl/core/mwsm_pkg.sv -----
// Shared types, widths and constants of the mecanum wheel speed mixer.
package mwsm_pkg;

  // Field and register widths
  localparam int VEL_W      = 16;
  localparam int LIM_W      = 15;
  localparam int WB_W       = 15;
  localparam int GAIN_W     = 16;
  localparam int DB_W       = 15;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Q4.12 to Q24 shift
  localparam int FRAC_SH = 12;

  // Internal widths
  localparam int P_W     = WB_W + VEL_W;        // L*yaw, signed
  localparam int MAG_W   = 30;                  // largest magnitude (|L*yaw|)
  localparam int NORM_W  = MAG_W + 1;           // L1 norm, unsigned
  localparam int LIM24_W = LIM_W + FRAC_SH;     // limit in Q24
  localparam int NUM_W   = MAG_W + LIM24_W;     // dividend |v| * lim24
  localparam int QUO_W   = LIM24_W;             // scaled magnitude
  localparam int DIV_STAGES = QUO_W;            // one quotient bit per stage
  localparam int U_W     = 32;                  // bounded velocity, signed
  localparam int SQ_IN_W = VEL_W + FRAC_SH;     // x, y, yaw fit in 28 bits
  localparam int SQ_W    = 2 * SQ_IN_W - 1;     // one square, unsigned
  localparam int SQS_W   = SQ_W + 2;            // sum of three squares
  localparam int RSQ_W   = 2 * (DB_W + FRAC_SH);
  localparam int PROD_W  = GAIN_W + 1 + U_W;    // gain * wheel sum, signed
  localparam int WHEEL_SH = 24;
  localparam int TRN_W   = PROD_W - WHEEL_SH;   // truncated speed
  localparam int WHL_W   = TRN_W + 1;           // after negation

  localparam logic [VEL_W-1:0] SPD_MAX = 16'h7FFF;
  localparam logic [VEL_W-1:0] SPD_MIN = 16'h8000;

  // Divider lanes
  localparam int N_LANES = 4;
  localparam int LANE_X  = 0;
  localparam int LANE_Y  = 1;
  localparam int LANE_W  = 2;
  localparam int LANE_P  = 3;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NORM_LIMIT      = 2'd0,
    CFG_WHEEL_BASE_SUM  = 2'd1,
    CFG_RPM_GAIN        = 2'd2,
    CFG_DEADBAND_RADIUS = 2'd3
  } cfg_idx_t;

  localparam logic [LIM_W-1:0]  NORM_LIMIT_RST      = 15'd1638;
  localparam logic [WB_W-1:0]   WHEEL_BASE_SUM_RST  = 15'd2116;
  localparam logic [GAIN_W-1:0] RPM_GAIN_RST        = 16'd9235;
  localparam logic [DB_W-1:0]   DEADBAND_RADIUS_RST = 15'd41;

  typedef struct packed {
    logic [LIM_W-1:0]  norm_limit;
    logic [WB_W-1:0]   wheel_base_sum;
    logic [GAIN_W-1:0] rpm_gain;
    logic [DB_W-1:0]   deadband_radius;
  } cfg_t;

  typedef struct packed {
    logic [NORM_W-1:0] rem;
    logic [QUO_W-1:0]  sh;   // dividend bits still to enter, quotient bits shift in
  } div_lane_t;

  typedef struct packed {
    div_lane_t [N_LANES-1:0]  lane;
    logic [NORM_W-1:0]        den;
    logic                     limited;
    logic [N_LANES-1:0]       neg;
    logic signed [VEL_W-1:0]  vel_x;
    logic signed [VEL_W-1:0]  vel_y;
    logic signed [VEL_W-1:0]  yaw_rate;
    logic signed [P_W-1:0]    p;
  } div_pl_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] speed_front_left;
    logic signed [VEL_W-1:0] speed_front_right;
    logic signed [VEL_W-1:0] speed_back_left;
    logic signed [VEL_W-1:0] speed_back_right;
    logic                    was_limited;
    logic                    in_deadband;
  } spd_t;

  function automatic logic [VEL_W-1:0] mag16(input logic signed [VEL_W-1:0] v);
    return v[VEL_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// ----- rtl/core/mwsm_if.sv -----
// Request channels of the mixer: velocity command in, wheel speeds out.
interface mwsm_cmd_if;
  logic                              valid;
  logic                              ready;
  logic signed [mwsm_pkg::VEL_W-1:0] vel_x;
  logic signed [mwsm_pkg::VEL_W-1:0] vel_y;
  logic signed [mwsm_pkg::VEL_W-1:0] yaw_rate;

  modport source (output valid, output vel_x, output vel_y, output yaw_rate, input ready);
  modport sink   (input valid, input vel_x, input vel_y, input yaw_rate, output ready);
endinterface

interface mwsm_spd_if;
  logic                              valid;
  logic                              ready;
  logic signed [mwsm_pkg::VEL_W-1:0] speed_front_left;
  logic signed [mwsm_pkg::VEL_W-1:0] speed_front_right;
  logic signed [mwsm_pkg::VEL_W-1:0] speed_back_left;
  logic signed [mwsm_pkg::VEL_W-1:0] speed_back_right;
  logic                              was_limited;
  logic                              in_deadband;

  modport source (output valid, output speed_front_left, output speed_front_right,
                  output speed_back_left, output speed_back_right,
                  output was_limited, output in_deadband, input ready);
  modport sink   (input valid, input speed_front_left, input speed_front_right,
                  input speed_back_left, input speed_back_right,
                  input was_limited, input in_deadband, output ready);
endinterface

// ----- rtl/core/mwsm_front.sv -----
// Front stages: L*yaw, magnitudes, L1 norm, limit test and divider dividends.
module mwsm_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mwsm_pkg::cfg_t                    cfg,
  input  logic                              up_valid,
  output logic                              up_en,
  input  logic signed [mwsm_pkg::VEL_W-1:0] vel_x,
  input  logic signed [mwsm_pkg::VEL_W-1:0] vel_y,
  input  logic signed [mwsm_pkg::VEL_W-1:0] yaw_rate,
  output logic                              dn_valid,
  input  logic                              dn_en,
  output mwsm_pkg::div_pl_t                 dn_pl
);

  logic [3:0] v_r;
  logic [3:0] en;

  // stage 0: input register
  logic signed [mwsm_pkg::VEL_W-1:0] x0_r, y0_r, w0_r;
  // stage 1: L*yaw
  logic signed [mwsm_pkg::VEL_W-1:0] x1_r, y1_r, w1_r;
  logic signed [mwsm_pkg::P_W-1:0]   p1_r, p1_nxt;
  logic signed [2*mwsm_pkg::VEL_W-1:0] p_full;
  // stage 2: magnitudes and norm
  logic signed [mwsm_pkg::VEL_W-1:0] x2_r, y2_r, w2_r;
  logic signed [mwsm_pkg::P_W-1:0]   p2_r;
  logic [mwsm_pkg::MAG_W-1:0]        m2_r [mwsm_pkg::N_LANES];
  logic [mwsm_pkg::MAG_W-1:0]        m2_nxt [mwsm_pkg::N_LANES];
  logic [mwsm_pkg::NORM_W-1:0]       norm2_r, norm2_nxt;
  logic [mwsm_pkg::P_W-1:0]          p_abs;
  // stage 3: dividends
  mwsm_pkg::div_pl_t                 pl3_r, pl3_nxt;
  logic [mwsm_pkg::LIM24_W-1:0]      lim24;
  logic [mwsm_pkg::NUM_W-1:0]        num [mwsm_pkg::N_LANES];

  always_comb begin
    en[3] = ~v_r[3] | dn_en;
    en[2] = ~v_r[2] | en[3];
    en[1] = ~v_r[1] | en[2];
    en[0] = ~v_r[0] | en[1];
  end
  assign up_en    = en[0];
  assign dn_valid = v_r[3];
  assign dn_pl    = pl3_r;

  always_comb begin
    p_full = $signed({1'b0, cfg.wheel_base_sum}) * w0_r;
    p1_nxt = p_full[mwsm_pkg::P_W-1:0];
  end

  always_comb begin
    p_abs = p1_r[mwsm_pkg::P_W-1] ? (~p1_r + 1'b1) : p1_r;
    m2_nxt[mwsm_pkg::LANE_X] = {2'b00, mwsm_pkg::mag16(x1_r), {mwsm_pkg::FRAC_SH{1'b0}}};
    m2_nxt[mwsm_pkg::LANE_Y] = {2'b00, mwsm_pkg::mag16(y1_r), {mwsm_pkg::FRAC_SH{1'b0}}};
    m2_nxt[mwsm_pkg::LANE_W] = {2'b00, mwsm_pkg::mag16(w1_r), {mwsm_pkg::FRAC_SH{1'b0}}};
    m2_nxt[mwsm_pkg::LANE_P] = p_abs[mwsm_pkg::MAG_W-1:0];
    // yaw itself is not part of the norm, only L*yaw
    norm2_nxt = {1'b0, m2_nxt[mwsm_pkg::LANE_X]} + {1'b0, m2_nxt[mwsm_pkg::LANE_Y]}
              + {1'b0, m2_nxt[mwsm_pkg::LANE_P]};
  end

  always_comb begin
    lim24 = {cfg.norm_limit, {mwsm_pkg::FRAC_SH{1'b0}}};
    for (int i = 0; i < mwsm_pkg::N_LANES; i++) begin
      num[i] = m2_r[i] * lim24;
      pl3_nxt.lane[i].rem = {1'b0, num[i][mwsm_pkg::NUM_W-1:mwsm_pkg::QUO_W]};
      pl3_nxt.lane[i].sh  = num[i][mwsm_pkg::QUO_W-1:0];
    end
    pl3_nxt.den      = norm2_r;
    pl3_nxt.limited  = norm2_r > {{(mwsm_pkg::NORM_W-mwsm_pkg::LIM24_W){1'b0}}, lim24};
    pl3_nxt.neg      = {p2_r[mwsm_pkg::P_W-1], w2_r[mwsm_pkg::VEL_W-1],
                        y2_r[mwsm_pkg::VEL_W-1], x2_r[mwsm_pkg::VEL_W-1]};
    pl3_nxt.vel_x    = x2_r;
    pl3_nxt.vel_y    = y2_r;
    pl3_nxt.yaw_rate = w2_r;
    pl3_nxt.p        = p2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0_r <= vel_x;
      y0_r <= vel_y;
      w0_r <= yaw_rate;
    end
    if (en[1]) begin
      x1_r <= x0_r;
      y1_r <= y0_r;
      w1_r <= w0_r;
      p1_r <= p1_nxt;
    end
    if (en[2]) begin
      x2_r    <= x1_r;
      y2_r    <= y1_r;
      w2_r    <= w1_r;
      p2_r    <= p1_r;
      m2_r    <= m2_nxt;
      norm2_r <= norm2_nxt;
    end
    if (en[3]) pl3_r <= pl3_nxt;
  end

endmodule

// ----- rtl/core/mwsm_div_stage.sv -----
// One restoring-division step for all four lanes: one quotient bit each.
module mwsm_div_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_en,
  input  mwsm_pkg::div_pl_t up_pl,
  output logic              dn_valid,
  input  logic              dn_en,
  output mwsm_pkg::div_pl_t dn_pl
);

  logic              v_r;
  logic              en;
  mwsm_pkg::div_pl_t pl_r, pl_nxt;
  logic [mwsm_pkg::NORM_W:0] t    [mwsm_pkg::N_LANES];
  logic [mwsm_pkg::NORM_W:0] diff [mwsm_pkg::N_LANES];
  logic [mwsm_pkg::N_LANES-1:0] ge;

  assign en       = ~v_r | dn_en;
  assign up_en    = en;
  assign dn_valid = v_r;
  assign dn_pl    = pl_r;

  always_comb begin
    pl_nxt = up_pl;
    for (int i = 0; i < mwsm_pkg::N_LANES; i++) begin
      t[i]    = {up_pl.lane[i].rem, up_pl.lane[i].sh[mwsm_pkg::QUO_W-1]};
      diff[i] = t[i] - {1'b0, up_pl.den};
      ge[i]   = t[i] >= {1'b0, up_pl.den};
      pl_nxt.lane[i].rem = ge[i] ? diff[i][mwsm_pkg::NORM_W-1:0]
                                 : t[i][mwsm_pkg::NORM_W-1:0];
      pl_nxt.lane[i].sh  = {up_pl.lane[i].sh[mwsm_pkg::QUO_W-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) pl_r <= pl_nxt;
  end

endmodule

// ----- rtl/core/mwsm_back.sv -----
// Back stages: bounded command, deadband test, wheel mixing, gain and saturation.
module mwsm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mwsm_pkg::cfg_t    cfg,
  input  logic              up_valid,
  output logic              up_en,
  input  mwsm_pkg::div_pl_t up_pl,
  output logic              dn_valid,
  input  logic              dn_en,
  output mwsm_pkg::spd_t    dn_spd
);

  logic [3:0] v_r;
  logic [3:0] en;

  // stage 0: bounded velocities (x, y, yaw, L*yaw)
  logic signed [mwsm_pkg::U_W-1:0] u0_r   [mwsm_pkg::N_LANES];
  logic signed [mwsm_pkg::U_W-1:0] u0_nxt [mwsm_pkg::N_LANES];
  logic [mwsm_pkg::U_W-1:0]        q_ext;
  logic                            lim0_r;
  // stage 1: squares and wheel sums (fl, fr, bl, br)
  logic [mwsm_pkg::SQ_W-1:0]       sq1_r  [3];
  logic [mwsm_pkg::SQ_W-1:0]       sq1_nxt [3];
  logic signed [2*mwsm_pkg::SQ_IN_W-1:0] sq_full [3];
  logic signed [mwsm_pkg::SQ_IN_W-1:0]   sq_in   [3];
  logic signed [mwsm_pkg::U_W-1:0] s1_r   [4];
  logic signed [mwsm_pkg::U_W-1:0] s1_nxt [4];
  logic                            lim1_r;
  // stage 2: sum of squares, gain products, radius squared
  logic [mwsm_pkg::SQS_W-1:0]       sqs2_r, sqs2_nxt;
  logic signed [mwsm_pkg::PROD_W-1:0] pr2_r   [4];
  logic signed [mwsm_pkg::PROD_W-1:0] pr2_nxt [4];
  logic [2*mwsm_pkg::DB_W-1:0]      r_sq;
  logic [mwsm_pkg::RSQ_W-1:0]       rsq2_r, rsq2_nxt;
  logic                             lim2_r;
  // stage 3: output register
  mwsm_pkg::spd_t                   spd_r, spd_nxt;
  logic signed [mwsm_pkg::PROD_W-1:0] biased [4];
  logic signed [mwsm_pkg::WHL_W-1:0]  whl    [4];
  logic [mwsm_pkg::VEL_W-1:0]         sat    [4];
  logic                               dead;

  function automatic logic [mwsm_pkg::VEL_W-1:0] sat_spd(
    input logic signed [mwsm_pkg::WHL_W-1:0] v);
    logic [mwsm_pkg::WHL_W-mwsm_pkg::VEL_W:0] top;
    top = v[mwsm_pkg::WHL_W-1:mwsm_pkg::VEL_W-1];
    if (top == '0 || top == '1) return v[mwsm_pkg::VEL_W-1:0];
    return v[mwsm_pkg::WHL_W-1] ? mwsm_pkg::SPD_MIN : mwsm_pkg::SPD_MAX;
  endfunction

  always_comb begin
    en[3] = ~v_r[3] | dn_en;
    en[2] = ~v_r[2] | en[3];
    en[1] = ~v_r[1] | en[2];
    en[0] = ~v_r[0] | en[1];
  end
  assign up_en    = en[0];
  assign dn_valid = v_r[3];
  assign dn_spd   = spd_r;

  // stage 0: signed quotient when limited, plain Q24 command otherwise
  always_comb begin
    q_ext = '0;
    if (up_pl.limited) begin
      for (int i = 0; i < mwsm_pkg::N_LANES; i++) begin
        q_ext     = {{(mwsm_pkg::U_W-mwsm_pkg::QUO_W){1'b0}}, up_pl.lane[i].sh};
        u0_nxt[i] = up_pl.neg[i] ? $signed(~q_ext + 1'b1) : $signed(q_ext);
      end
    end else begin
      u0_nxt[mwsm_pkg::LANE_X] = {{(mwsm_pkg::U_W-mwsm_pkg::SQ_IN_W){up_pl.vel_x[mwsm_pkg::VEL_W-1]}},
                                  up_pl.vel_x, {mwsm_pkg::FRAC_SH{1'b0}}};
      u0_nxt[mwsm_pkg::LANE_Y] = {{(mwsm_pkg::U_W-mwsm_pkg::SQ_IN_W){up_pl.vel_y[mwsm_pkg::VEL_W-1]}},
                                  up_pl.vel_y, {mwsm_pkg::FRAC_SH{1'b0}}};
      u0_nxt[mwsm_pkg::LANE_W] = {{(mwsm_pkg::U_W-mwsm_pkg::SQ_IN_W){up_pl.yaw_rate[mwsm_pkg::VEL_W-1]}},
                                  up_pl.yaw_rate, {mwsm_pkg::FRAC_SH{1'b0}}};
      u0_nxt[mwsm_pkg::LANE_P] = {{(mwsm_pkg::U_W-mwsm_pkg::P_W){up_pl.p[mwsm_pkg::P_W-1]}}, up_pl.p};
    end
  end

  // stage 1
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_in[i]   = u0_r[i][mwsm_pkg::SQ_IN_W-1:0];
      sq_full[i] = sq_in[i] * sq_in[i];
      sq1_nxt[i] = sq_full[i][mwsm_pkg::SQ_W-1:0];
    end
    s1_nxt[0] = u0_r[mwsm_pkg::LANE_X] - u0_r[mwsm_pkg::LANE_Y] - u0_r[mwsm_pkg::LANE_P];
    s1_nxt[1] = u0_r[mwsm_pkg::LANE_X] + u0_r[mwsm_pkg::LANE_Y] + u0_r[mwsm_pkg::LANE_P];
    s1_nxt[2] = u0_r[mwsm_pkg::LANE_X] + u0_r[mwsm_pkg::LANE_Y] - u0_r[mwsm_pkg::LANE_P];
    s1_nxt[3] = u0_r[mwsm_pkg::LANE_X] - u0_r[mwsm_pkg::LANE_Y] + u0_r[mwsm_pkg::LANE_P];
  end

  // stage 2
  always_comb begin
    sqs2_nxt = {2'b00, sq1_r[0]} + {2'b00, sq1_r[1]} + {2'b00, sq1_r[2]};
    for (int i = 0; i < 4; i++) begin
      pr2_nxt[i] = $signed({1'b0, cfg.rpm_gain}) * s1_r[i];
    end
    r_sq     = cfg.deadband_radius * cfg.deadband_radius;
    rsq2_nxt = {r_sq, {(2*mwsm_pkg::FRAC_SH){1'b0}}};
  end

  // stage 3: truncate toward zero, negate right wheels, saturate, zero in the deadband
  always_comb begin
    dead = sqs2_r < {{(mwsm_pkg::SQS_W-mwsm_pkg::RSQ_W){1'b0}}, rsq2_r};
    for (int i = 0; i < 4; i++) begin
      biased[i] = pr2_r[i] + (pr2_r[i][mwsm_pkg::PROD_W-1]
                  ? $signed({{(mwsm_pkg::PROD_W-mwsm_pkg::WHEEL_SH){1'b0}},
                             {mwsm_pkg::WHEEL_SH{1'b1}}})
                  : $signed({mwsm_pkg::PROD_W{1'b0}}));
      whl[i] = {biased[i][mwsm_pkg::PROD_W-1], biased[i][mwsm_pkg::PROD_W-1:mwsm_pkg::WHEEL_SH]};
      if (i == 1 || i == 3) whl[i] = -whl[i];
      sat[i] = dead ? '0 : sat_spd(whl[i]);
    end
    spd_nxt.speed_front_left  = sat[0];
    spd_nxt.speed_front_right = sat[1];
    spd_nxt.speed_back_left   = sat[2];
    spd_nxt.speed_back_right  = sat[3];
    spd_nxt.was_limited       = lim2_r;
    spd_nxt.in_deadband       = dead;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      u0_r   <= u0_nxt;
      lim0_r <= up_pl.limited;
    end
    if (en[1]) begin
      sq1_r  <= sq1_nxt;
      s1_r   <= s1_nxt;
      lim1_r <= lim0_r;
    end
    if (en[2]) begin
      sqs2_r <= sqs2_nxt;
      pr2_r  <= pr2_nxt;
      rsq2_r <= rsq2_nxt;
      lim2_r <= lim1_r;
    end
    if (en[3]) spd_r <= spd_nxt;
  end

endmodule

// ----- rtl/core/mecanum_wheel_speed_mixer_unit.sv -----
// Throughput: one request per cycle while out_spd is ready; the 27-stage divider (one quotient bit
//   per stage, four lanes) and every other stage take a new request each cycle.
// Stalls are local: a stage holding no request still loads, so bubbles close up.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register
//   defaults: norm_limit 1638, wheel_base_sum 2116, rpm_gain 9235, deadband 41.
module mecanum_wheel_speed_mixer_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  mwsm_cmd_if.sink                             in_cmd,
  mwsm_spd_if.source                           out_spd,
  input  logic                                 cfg_we,
  input  logic [mwsm_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [mwsm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  mwsm_pkg::cfg_t    cfg_r;

  // Divider chain: index 0 is the front's output, index DIV_STAGES the back's input.
  mwsm_pkg::div_pl_t div_pl    [mwsm_pkg::DIV_STAGES+1];
  logic              div_valid [mwsm_pkg::DIV_STAGES+1];
  logic              div_en    [mwsm_pkg::DIV_STAGES+1];

  mwsm_pkg::spd_t    spd;
  logic              spd_valid;

  // Configuration registers; the user must write them only while no request is
  // in flight (the block does not enforce it), so every stage reads them directly.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.norm_limit      <= mwsm_pkg::NORM_LIMIT_RST;
      cfg_r.wheel_base_sum  <= mwsm_pkg::WHEEL_BASE_SUM_RST;
      cfg_r.rpm_gain        <= mwsm_pkg::RPM_GAIN_RST;
      cfg_r.deadband_radius <= mwsm_pkg::DEADBAND_RADIUS_RST;
    end else if (cfg_we) begin
      unique case (mwsm_pkg::cfg_idx_t'(cfg_idx))
        mwsm_pkg::CFG_NORM_LIMIT:      cfg_r.norm_limit      <= cfg_data[mwsm_pkg::LIM_W-1:0];
        mwsm_pkg::CFG_WHEEL_BASE_SUM:  cfg_r.wheel_base_sum  <= cfg_data[mwsm_pkg::WB_W-1:0];
        mwsm_pkg::CFG_RPM_GAIN:        cfg_r.rpm_gain        <= cfg_data[mwsm_pkg::GAIN_W-1:0];
        mwsm_pkg::CFG_DEADBAND_RADIUS: cfg_r.deadband_radius <= cfg_data[mwsm_pkg::DB_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: input register, L*yaw, L1 norm, limit compare, dividends |v|*limit.
  mwsm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_cmd.valid),
    .up_en    (in_cmd.ready),
    .vel_x    (in_cmd.vel_x),
    .vel_y    (in_cmd.vel_y),
    .yaw_rate (in_cmd.yaw_rate),
    .dn_valid (div_valid[0]),
    .dn_en    (div_en[0]),
    .dn_pl    (div_pl[0])
  );

  // Scaling by limit/norm: x, y, yaw and L*yaw divided by the norm in four
  // parallel lanes. The quotient is always below 2^27 when the command is
  // limited; an unlimited command carries its own values past the divider.
  for (genvar k = 0; k < mwsm_pkg::DIV_STAGES; k++) begin : g_div
    mwsm_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (div_valid[k]),
      .up_en    (div_en[k]),
      .up_pl    (div_pl[k]),
      .dn_valid (div_valid[k+1]),
      .dn_en    (div_en[k+1]),
      .dn_pl    (div_pl[k+1])
    );
  end

  // Back: bounded command, squares, wheel sums, gain, deadband, saturation.
  mwsm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (div_valid[mwsm_pkg::DIV_STAGES]),
    .up_en    (div_en[mwsm_pkg::DIV_STAGES]),
    .up_pl    (div_pl[mwsm_pkg::DIV_STAGES]),
    .dn_valid (spd_valid),
    .dn_en    (out_spd.ready),
    .dn_spd   (spd)
  );

  assign out_spd.valid             = spd_valid;
  assign out_spd.speed_front_left  = spd.speed_front_left;
  assign out_spd.speed_front_right = spd.speed_front_right;
  assign out_spd.speed_back_left   = spd.speed_back_left;
  assign out_spd.speed_back_right  = spd.speed_back_right;
  assign out_spd.was_limited       = spd.was_limited;
  assign out_spd.in_deadband       = spd.in_deadband;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the mecanum wheel speed mixer: random and corner requests.
`timescale 1ns / 100ps

module tb;

  localparam int LATENCY     = 35;
  localparam int SETTLE      = LATENCY + 5;
  localparam int STALL_LIMIT = 2000;  // cycles with no accepted request on either side and no register write
  localparam int PHASE_ITEMS = 190;
  localparam int CALM_FROM   = 500;   // requests in this window go out with no idling
  localparam int CALM_TO     = 800;

  typedef struct packed {
    logic signed [mwsm_pkg::VEL_W-1:0] vx;
    logic signed [mwsm_pkg::VEL_W-1:0] vy;
    logic signed [mwsm_pkg::VEL_W-1:0] wz;
  } vel_cmd_t;

  // Keeps a copy of the four registers and the wheel speeds still owed by the block.
  class speed_ledger;
    logic [mwsm_pkg::LIM_W-1:0]  norm_limit;
    logic [mwsm_pkg::WB_W-1:0]   wheel_base_sum;
    logic [mwsm_pkg::GAIN_W-1:0] rpm_gain;
    logic [mwsm_pkg::DB_W-1:0]   deadband_radius;
    mwsm_pkg::spd_t              speeds_due[$];
    int                          errors;

    function new();
      norm_limit      = mwsm_pkg::NORM_LIMIT_RST;
      wheel_base_sum  = mwsm_pkg::WHEEL_BASE_SUM_RST;
      rpm_gain        = mwsm_pkg::RPM_GAIN_RST;
      deadband_radius = mwsm_pkg::DEADBAND_RADIUS_RST;
      errors          = 0;
    endfunction

    function void note_reg(mwsm_pkg::cfg_idx_t idx,
                           logic [mwsm_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        mwsm_pkg::CFG_NORM_LIMIT:      norm_limit      = data[mwsm_pkg::LIM_W-1:0];
        mwsm_pkg::CFG_WHEEL_BASE_SUM:  wheel_base_sum  = data[mwsm_pkg::WB_W-1:0];
        mwsm_pkg::CFG_RPM_GAIN:        rpm_gain        = data[mwsm_pkg::GAIN_W-1:0];
        mwsm_pkg::CFG_DEADBAND_RADIUS: deadband_radius = data[mwsm_pkg::DB_W-1:0];
        default: ;
      endcase
    endfunction

    // All velocities in Q24; L*yaw is scaled on its own, not rebuilt from the scaled yaw.
    function mwsm_pkg::spd_t mix_speeds(vel_cmd_t c);
      longint x, y, w, p, norm, lim, rad, v;
      longint sum[4];
      logic [mwsm_pkg::VEL_W-1:0] sp[4];
      logic limited, dead;
      mwsm_pkg::spd_t r;
      x    = longint'(c.vx) * 4096;
      y    = longint'(c.vy) * 4096;
      w    = longint'(c.wz) * 4096;
      p    = longint'(wheel_base_sum) * longint'(c.wz);
      norm = (x < 0 ? -x : x) + (y < 0 ? -y : y) + (p < 0 ? -p : p);
      lim  = longint'(norm_limit) * 4096;
      rad  = longint'(deadband_radius) * 4096;
      limited = norm > lim;
      if (limited) begin
        x = (x * lim) / norm;
        y = (y * lim) / norm;
        w = (w * lim) / norm;
        p = (p * lim) / norm;
      end
      dead = (x * x + y * y + w * w) < rad * rad;
      sum[0] = x - y - p;  // front left
      sum[1] = x + y + p;  // front right
      sum[2] = x + y - p;  // back left
      sum[3] = x - y + p;  // back right
      for (int i = 0; i < 4; i++) begin
        v = dead ? 0 : (longint'(rpm_gain) * sum[i]) / 64'sd16777216;
        if (i % 2 == 1) v = -v;  // right side motors are mounted mirrored
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        sp[i] = v[mwsm_pkg::VEL_W-1:0];
      end
      r.speed_front_left  = sp[0];
      r.speed_front_right = sp[1];
      r.speed_back_left   = sp[2];
      r.speed_back_right  = sp[3];
      r.was_limited       = limited;
      r.in_deadband       = dead;
      return r;
    endfunction

    function void note_cmd(vel_cmd_t c);
      speeds_due.insert(speeds_due.size(), mix_speeds(c));
    endfunction

    function void compare(string name, logic signed [mwsm_pkg::VEL_W-1:0] want,
                          logic signed [mwsm_pkg::VEL_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_spd(mwsm_pkg::spd_t got);
      mwsm_pkg::spd_t want;
      if (speeds_due.size() == 0) begin
        $error("wheel speed result with no request outstanding");
        errors++;
        return;
      end
      want = speeds_due.pop_front();
      compare("speed_front_left", want.speed_front_left, got.speed_front_left);
      compare("speed_front_right", want.speed_front_right, got.speed_front_right);
      compare("speed_back_left", want.speed_back_left, got.speed_back_left);
      compare("speed_back_right", want.speed_back_right, got.speed_back_right);
      compare("was_limited", 16'(want.was_limited), 16'(got.was_limited));
      compare("in_deadband", 16'(want.in_deadband), 16'(got.in_deadband));
    endfunction

    function int pending();
      return speeds_due.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  mwsm_pkg::cfg_idx_t cfg_idx;
  logic [mwsm_pkg::CFG_DATA_W-1:0] cfg_data;

  mwsm_cmd_if cmd();
  mwsm_spd_if spd();

  speed_ledger ledger = new();

  int   cmds_sent   = 0;
  int   stall_count = 0;
  logic calm        = 1'b0;  // both sides stop idling while this is high

  mecanum_wheel_speed_mixer_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_cmd   (cmd),
    .out_spd  (spd),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Full-range values most often, plus small ones near the deadband, mid-range ones
  // around the norm limit and the extremes of the field.
  function automatic logic signed [mwsm_pkg::VEL_W-1:0] pick_vel();
    logic signed [mwsm_pkg::VEL_W-1:0] ends[6];
    ends = '{16'sh8000, 16'sh8001, 16'shFFFF, 16'sh0000, 16'sh0001, 16'sh7FFF};
    case ($urandom_range(9)) inside
      [0:3]:   return 16'($urandom);
      [4:6]:   return 16'($urandom_range(128) - 64);
      [7:8]:   return 16'($urandom_range(8192) - 4096);
      default: return ends[$urandom_range(5)];
    endcase
  endfunction

  // Offer one request, idling now and then first; returns once it is accepted.
  // Valid stays high on return so back-to-back requests follow with no idle gap.
  task automatic send_cmd(vel_cmd_t c);
    while (!calm && $urandom_range(99) < 8) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid    <= 1'b1;
    cmd.vel_x    <= c.vx;
    cmd.vel_y    <= c.vy;
    cmd.yaw_rate <= c.wz;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    ledger.note_cmd(c);
    cmds_sent++;
    calm <= (cmds_sent >= CALM_FROM) && (cmds_sent < CALM_TO);
  endtask

  // Stop offering and wait for every outstanding request to come back.
  task automatic drain();
    cmd.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  // Registers are only touched while the pipeline is empty.
  task automatic load_cfg(input logic [mwsm_pkg::CFG_DATA_W-1:0] lim, wb, gain, db);
    mwsm_pkg::cfg_idx_t regs[4];
    logic [mwsm_pkg::CFG_DATA_W-1:0] vals[4];
    regs = '{mwsm_pkg::CFG_NORM_LIMIT, mwsm_pkg::CFG_WHEEL_BASE_SUM,
             mwsm_pkg::CFG_RPM_GAIN, mwsm_pkg::CFG_DEADBAND_RADIUS};
    vals = '{lim, wb, gain, db};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      ledger.note_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // n random requests; with hold set, the sender stops halfway until all are back.
  task automatic send_random(int n, bit hold);
    vel_cmd_t c;
    for (int i = 0; i < n; i++) begin
      if (hold && i == n / 2) drain();
      c.vx = pick_vel();
      c.vy = pick_vel();
      c.wz = pick_vel();
      send_cmd(c);
    end
  endtask

  // Main sequence: reset, corner requests at default settings, then phases of
  // random requests under several register settings, extremes included.
  initial begin
    vel_cmd_t corners[$];
    cmd.valid    <= 1'b0;
    cmd.vel_x    <= '0;
    cmd.vel_y    <= '0;
    cmd.yaw_rate <= '0;
    cfg_we       <= 1'b0;
    cfg_idx      <= mwsm_pkg::CFG_NORM_LIMIT;
    cfg_data     <= '0;
    rst_n        <= 1'b0;
    corners = '{
      '{16'sh0000, 16'sh0000, 16'sh0000},  // standing still: inside the deadband
      '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF},  // every field at its top
      '{16'sh8000, 16'sh8000, 16'sh8000},  // every field at its bottom
      '{16'sh7FFF, 16'sh8000, 16'sh0000},
      '{16'sh8000, 16'sh7FFF, 16'sh7FFF},
      '{16'sh7FFF, 16'sh0000, 16'sh0000},
      '{16'sd1638, 16'sh0000, 16'sh0000},  // norm exactly at the limit: not scaled
      '{16'sd1639, 16'sh0000, 16'sh0000},  // one step over the limit
      '{16'sh0000, 16'sd1638, 16'sh0000},
      '{16'sh0000, 16'sh0000, 16'sh0001},
      '{16'sd40,   16'sh0000, 16'sh0000},  // just inside the deadband
      '{16'sd41,   16'sh0000, 16'sh0000},  // on the deadband edge: wheels turn
      '{16'sd28,   16'sd28,   16'sh0000},
      '{16'sh0000, 16'sh0000, -16'sd41},
      '{16'shFFFF, 16'shFFFF, 16'shFFFF},
      '{16'sd4096, 16'sh0000, 16'sh0000},  // pure forward, pure sideways, pure yaw
      '{16'sh0000, -16'sd4096, 16'sh0000},
      '{16'sh0000, 16'sh0000, 16'sd4096},
      '{16'sd1000, 16'sd500,  -16'sd1000},
      '{-16'sd300, 16'sd700,  16'sd200}
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corners[i]) send_cmd(corners[i]);
    send_random(PHASE_ITEMS, 1'b0);

    // general random setting, deadband kept small so most requests move the wheels
    load_cfg(16'($urandom_range(32767)), 16'($urandom_range(32767)),
             16'($urandom_range(65535)), 16'($urandom_range(400)));
    send_random(PHASE_ITEMS, 1'b0);
    // zero norm limit: every moving request collapses into the deadband
    load_cfg(16'd0, 16'($urandom_range(32767)), 16'($urandom_range(65535)), 16'd41);
    send_random(PHASE_ITEMS, 1'b0);
    // widest limit, base and gain with no deadband: saturation territory
    load_cfg(16'd32767, 16'd32767, 16'd65535, 16'd0);
    send_random(PHASE_ITEMS, 1'b0);
    // no yaw lever, zero gain, largest deadband
    load_cfg(16'd32767, 16'd0, 16'd0, 16'd32767);
    send_random(PHASE_ITEMS, 1'b0);
    // full gain; sender holds off halfway until the pipeline is empty
    load_cfg(16'($urandom_range(32767)), 16'($urandom_range(32767)), 16'd65535,
             16'($urandom_range(200)));
    send_random(PHASE_ITEMS, 1'b1);
    // raw 16-bit data: the top bit must be dropped by the 15-bit registers
    load_cfg(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    send_random(PHASE_ITEMS, 1'b0);
    // back to the reset values, written explicitly
    load_cfg(16'(mwsm_pkg::NORM_LIMIT_RST), 16'(mwsm_pkg::WHEEL_BASE_SUM_RST),
             16'(mwsm_pkg::RPM_GAIN_RST), 16'(mwsm_pkg::DEADBAND_RADIUS_RST));
    send_random(PHASE_ITEMS, 1'b0);

    drain();
    repeat (SETTLE) @(posedge clk);
    if (ledger.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Result side: values are taken at the edge, before the block updates them.
  initial begin
    mwsm_pkg::spd_t got;
    spd.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && spd.valid && spd.ready) begin
        got.speed_front_left  = spd.speed_front_left;
        got.speed_front_right = spd.speed_front_right;
        got.speed_back_left   = spd.speed_back_left;
        got.speed_back_right  = spd.speed_back_right;
        got.was_limited       = spd.was_limited;
        got.in_deadband       = spd.in_deadband;
        ledger.check_spd(got);
      end
      spd.ready <= calm || ($urandom_range(99) >= 8);
    end
  end

  // Watchdog: a hung block shows up as a long run of cycles with no progress.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (cmd.valid && cmd.ready) || (spd.valid && spd.ready))
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

// ----- files.f -----
rtl/core/mwsm_pkg.sv
rtl/core/mwsm_if.sv
rtl/core/mwsm_front.sv
rtl/core/mwsm_div_stage.sv
rtl/core/mwsm_back.sv
rtl/core/mecanum_wheel_speed_mixer_unit.sv
tb/tb.sv
